[hdl/smbsv_pkg.sv]
// ----------------------------------------------------------------------------
// smbsv_pkg
// shared types, constants and md5 round tables for the message sign/verify core
// ----------------------------------------------------------------------------
package smbsv_pkg;

  localparam int MaxKeyBytes = 40;
  localparam int HeaderBytes = 32;
  localparam int SigOffset   = 14;
  localparam int SigBytes    = 8;

  localparam logic [63:0] PlaceholderSig = 64'h0059_4C50_5352_5342;
  localparam logic [31:0] SeqStep        = 32'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOKEY  = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [1:0] ST_BADSIG = 2'd3;

  localparam logic [2:0] CFG_KEY_LEN   = 3'd0;
  localparam logic [2:0] CFG_KEY_W0    = 3'd1;
  localparam logic [2:0] CFG_KEY_W1    = 3'd2;
  localparam logic [2:0] CFG_KEY_W2    = 3'd3;
  localparam logic [2:0] CFG_KEY_W3    = 3'd4;
  localparam logic [2:0] CFG_KEY_W4    = 3'd5;
  localparam logic [2:0] CFG_SEQ_START = 3'd6;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } md5_st_t;

  localparam md5_st_t Md5Init = '{a: 32'h67452301, b: 32'hefcdab89,
                                  c: 32'h98badcfe, d: 32'h10325476};

  function automatic word_t md5_k(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
      6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
      6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] g;
    j = i[3:0];
    unique case (i[5:4])
      2'd0:    g = j;
      2'd1:    g = 4'(j * 4'd5 + 4'd1);
      2'd2:    g = 4'(j * 4'd3 + 4'd5);
      default: g = 4'(j * 4'd7);
    endcase
    return g;
  endfunction

endpackage

[hdl/smbsv_if.sv]
// ----------------------------------------------------------------------------
// smbsv_in_if / smbsv_out_if
// valid/ready channels for message bytes and sign/verify results
// ----------------------------------------------------------------------------
interface smbsv_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] request_seqno;

  modport source (output valid, cmd, data_byte, last_byte, request_seqno, input ready);
  modport sink   (input valid, cmd, data_byte, last_byte, request_seqno, output ready);
endinterface

interface smbsv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] signature;
  logic [31:0] seqno_used;

  modport source (output valid, status, signature, seqno_used, input ready);
  modport sink   (input valid, status, signature, seqno_used, output ready);
endinterface

[hdl/smbsv_ram.sv]
// ----------------------------------------------------------------------------
// smbsv_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module smbsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[hdl/smbsv_md5_round.sv]
// ----------------------------------------------------------------------------
// smbsv_md5_round
// one md5 round step, shared across all 64 rounds of a compression
// ----------------------------------------------------------------------------
module smbsv_md5_round (
  input  smbsv_pkg::md5_st_t st_i,
  input  smbsv_pkg::word_t   w_i,
  input  logic [5:0]         rnd_i,
  output smbsv_pkg::md5_st_t st_o
);

  smbsv_pkg::word_t f;
  smbsv_pkg::word_t t;
  logic [63:0]      dbl;

  always_comb begin
    unique case (rnd_i[5:4])
      2'd0:    f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      2'd1:    f = (st_i.d & st_i.b) | (~st_i.d & st_i.c);
      2'd2:    f = st_i.b ^ st_i.c ^ st_i.d;
      default: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
    t    = st_i.a + f + smbsv_pkg::md5_k(rnd_i) + w_i;
    dbl  = {t, t} << smbsv_pkg::md5_s(rnd_i);
    st_o.a = st_i.d;
    st_o.b = st_i.b + dbl[63:32];
    st_o.c = st_i.b;
    st_o.d = st_i.c;
  end

endmodule

[hdl/smb_message_sign_verify_core.sv]
// ----------------------------------------------------------------------------
// smb_message_sign_verify_core
// md5 message signing and verification over key and message, one byte a word
//
//   channel  dir  word                                         handshake
//   in_ch    in   cmd, data_byte, last_byte, request_seqno     valid/ready
//   out_ch   out  status, signature, seqno_used                valid/ready
//   cfg_*    in   cfg_index, cfg_wdata                         cfg_we, no stall
//
// a message byte is absorbed in S_BYTE; the first byte of a message first absorbs the key bytes in S_KEY
// every filled 64-byte block is compressed in the shared md5 round unit (S_CPRE, S_CRND, S_CADD)
// the last byte adds padding (up to 72 bytes) and one or two blocks
// reset is synchronous, no clearing pass; in_ch stalls while a byte is at work
// a result waits in the output register, the next word is taken meanwhile
// ----------------------------------------------------------------------------
module smb_message_sign_verify_core (
  input  logic               clk,
  input  logic               rst_n,
  smbsv_in_if.sink           in_ch,
  smbsv_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_KEY  = 4'd1;
  localparam logic [3:0] S_BYTE = 4'd2;
  localparam logic [3:0] S_DEC  = 4'd3;
  localparam logic [3:0] S_PAD  = 4'd4;
  localparam logic [3:0] S_CPRE = 4'd5;
  localparam logic [3:0] S_CRND = 4'd6;
  localparam logic [3:0] S_CADD = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_RES  = 4'd9;

  logic [3:0]         state_r, state_nxt, ret_r;
  smbsv_pkg::md5_st_t chain_r, work_r, round_o;
  logic [5:0]         rnd_r;
  logic [63:0]        len_r;
  logic [23:0]        asm_r;
  logic [31:0]        off_r, cnt_r;
  logic [63:0]        rsig_r;
  logic [5:0]         key_len_r, kl_r, kidx_r, kl_clamp;
  logic [63:0]        key_r [5];
  logic               cmd_r, last_r;
  logic [7:0]         byte_r;
  logic [31:0]        rq_r;
  logic [63:0]        bits_r;
  logic               first_r, lenph_r;
  logic [2:0]         lcnt_r;
  logic [1:0]         res_status_r;
  logic [63:0]        res_sig_r;
  logic [31:0]        res_seq_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [63:0]        out_sig_r;
  logic [31:0]        out_seq_r;

  logic        abs_en, wrap, lenph_now, in_sig, can_load;
  logic [7:0]  abs_byte, hb;
  logic [63:0] len_inc, digest;
  logic [31:0] seq, rq_inc;
  logic [2:0]  sig_pos;
  logic [3:0]  cont;
  logic        ram_we;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.signature = out_sig_r;
  assign out_ch.seqno_used = out_seq_r;

  assign kl_clamp = (key_len_r > 6'(smbsv_pkg::MaxKeyBytes)) ?
                    6'(smbsv_pkg::MaxKeyBytes) : key_len_r;
  assign rq_inc   = rq_r + 32'd1;
  assign seq      = cmd_r ? rq_inc : cnt_r;
  assign in_sig   = (off_r >= 32'(smbsv_pkg::SigOffset)) &&
                    (off_r < 32'(smbsv_pkg::SigOffset + smbsv_pkg::SigBytes));
  assign sig_pos  = 3'(off_r - 32'(smbsv_pkg::SigOffset));
  assign hb       = !in_sig ? byte_r : (sig_pos < 3'd4) ? seq[8*sig_pos[1:0] +: 8] : 8'd0;
  assign lenph_now = lenph_r || (!first_r && len_r[5:0] == 6'd56);
  assign digest   = {chain_r.b, chain_r.a};
  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    abs_en   = 1'b0;
    abs_byte = 8'd0;
    unique case (state_r)
      S_KEY: begin
        abs_en   = 1'b1;
        abs_byte = key_r[kidx_r[5:3]][8*kidx_r[2:0] +: 8];
      end
      S_BYTE: begin
        abs_en   = 1'b1;
        abs_byte = hb;
      end
      S_PAD: begin
        abs_en   = 1'b1;
        abs_byte = first_r ? 8'h80 : lenph_now ? bits_r[8*lcnt_r +: 8] : 8'd0;
      end
      default: ;
    endcase
  end

  assign len_inc = len_r + 64'd1;
  assign wrap    = abs_en && (len_inc[5:0] == 6'd0);
  assign ram_we  = abs_en && (len_r[1:0] == 2'd3);

  always_comb begin
    unique case (state_r)
      S_CRND:  ram_raddr = smbsv_pkg::md5_g(rnd_r + 6'd1);
      default: ram_raddr = smbsv_pkg::md5_g(6'd0);
    endcase
  end

  smbsv_ram #(.WIDTH(32), .DEPTH(16)) u_block (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[5:2]),
    .wdata ({abs_byte, asm_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  smbsv_md5_round u_round (
    .st_i  (work_r),
    .w_i   (ram_rdata),
    .rnd_i (rnd_r),
    .st_o  (round_o)
  );

  // continuation after an absorb, and the state sequencer
  always_comb begin
    cont = S_IDLE;
    unique case (state_r)
      S_KEY:   cont = (kidx_r == kl_r - 6'd1) ? S_BYTE : S_KEY;
      S_BYTE:  cont = last_r ? S_DEC : S_IDLE;
      S_PAD:   cont = (lenph_now && lcnt_r == 3'd7) ? S_FIN : S_PAD;
      default: cont = S_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (off_r == 32'd0 && kl_clamp != 6'd0) ? S_KEY : S_BYTE;
        end
      end
      S_KEY, S_BYTE, S_PAD: state_nxt = wrap ? S_CPRE : cont;
      S_DEC: begin
        if (cmd_r == 1'b0) begin
          state_nxt = (off_r < 32'(smbsv_pkg::HeaderBytes) || key_len_r == 6'd0) ?
                      S_RES : S_PAD;
        end else begin
          state_nxt = (key_len_r == 6'd0 || off_r < 32'(smbsv_pkg::HeaderBytes)) ?
                      S_RES : S_PAD;
        end
      end
      S_CPRE: state_nxt = S_CRND;
      S_CRND: state_nxt = (rnd_r == 6'd63) ? S_CADD : S_CRND;
      S_CADD: state_nxt = ret_r;
      S_FIN:  state_nxt = S_RES;
      S_RES:  state_nxt = can_load ? S_IDLE : S_RES;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      chain_r     <= smbsv_pkg::Md5Init;
      len_r       <= 64'd0;
      off_r       <= 32'd0;
      cnt_r       <= 32'd0;
      rsig_r      <= 64'd0;
      key_len_r   <= 6'd0;
      for (int i = 0; i < 5; i++) key_r[i] <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.ready && state_r != S_RES) begin
        out_valid_r <= 1'b0;
      end
      if (abs_en) begin
        len_r <= len_inc;
        if (len_r[1:0] != 2'd3) begin
          asm_r[8*len_r[1:0] +: 8] <= abs_byte;
        end
        if (wrap) begin
          ret_r <= cont;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r  <= in_ch.cmd;
            byte_r <= in_ch.data_byte;
            last_r <= in_ch.last_byte;
            rq_r   <= in_ch.request_seqno;
            if (off_r == 32'd0) begin
              chain_r <= smbsv_pkg::Md5Init;
              len_r   <= 64'd0;
              rsig_r  <= 64'd0;
              kl_r    <= kl_clamp;
              kidx_r  <= 6'd0;
            end
          end
        end
        S_KEY: kidx_r <= kidx_r + 6'd1;
        S_BYTE: begin
          if (in_sig) begin
            rsig_r[8*sig_pos +: 8] <= byte_r;
          end
          if (off_r != 32'hFFFF_FFFF) begin
            off_r <= off_r + 32'd1;
          end
        end
        S_DEC: begin
          off_r        <= 32'd0;
          res_seq_r    <= 32'd0;
          bits_r       <= {len_r[60:0], 3'd0};
          first_r      <= 1'b1;
          lenph_r      <= 1'b0;
          lcnt_r       <= 3'd0;
          priority if (cmd_r == 1'b0 && off_r < 32'(smbsv_pkg::HeaderBytes)) begin
            res_status_r <= smbsv_pkg::ST_SHORT;
            res_sig_r    <= 64'd0;
          end else if (cmd_r == 1'b0 && key_len_r == 6'd0) begin
            res_status_r <= smbsv_pkg::ST_NOKEY;
            res_sig_r    <= smbsv_pkg::PlaceholderSig;
          end else if (key_len_r == 6'd0) begin
            res_status_r <= smbsv_pkg::ST_NOKEY;
            res_sig_r    <= 64'd0;
          end else if (off_r < 32'(smbsv_pkg::HeaderBytes)) begin
            res_status_r <= smbsv_pkg::ST_SHORT;
            res_sig_r    <= 64'd0;
          end else begin
            res_status_r <= smbsv_pkg::ST_OK;
            res_sig_r    <= 64'd0;
          end
        end
        S_PAD: begin
          first_r <= 1'b0;
          if (lenph_now) begin
            lenph_r <= 1'b1;
            lcnt_r  <= lcnt_r + 3'd1;
          end
        end
        S_CPRE: begin
          work_r <= chain_r;
          rnd_r  <= 6'd0;
        end
        S_CRND: begin
          work_r <= round_o;
          rnd_r  <= rnd_r + 6'd1;
        end
        S_CADD: begin
          chain_r.a <= chain_r.a + work_r.a;
          chain_r.b <= chain_r.b + work_r.b;
          chain_r.c <= chain_r.c + work_r.c;
          chain_r.d <= chain_r.d + work_r.d;
        end
        S_FIN: begin
          res_sig_r <= digest;
          if (cmd_r == 1'b0) begin
            res_status_r <= smbsv_pkg::ST_OK;
            res_seq_r    <= cnt_r;
            cnt_r        <= cnt_r + smbsv_pkg::SeqStep;
          end else begin
            res_seq_r    <= rq_inc;
            res_status_r <= (digest == rsig_r) ? smbsv_pkg::ST_OK : smbsv_pkg::ST_BADSIG;
          end
        end
        S_RES: begin
          if (can_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_sig_r    <= res_sig_r;
            out_seq_r    <= res_seq_r;
          end
        end
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          smbsv_pkg::CFG_KEY_LEN:   key_len_r <= cfg_wdata[5:0];
          smbsv_pkg::CFG_KEY_W0:    key_r[0]  <= cfg_wdata;
          smbsv_pkg::CFG_KEY_W1:    key_r[1]  <= cfg_wdata;
          smbsv_pkg::CFG_KEY_W2:    key_r[2]  <= cfg_wdata;
          smbsv_pkg::CFG_KEY_W3:    key_r[3]  <= cfg_wdata;
          smbsv_pkg::CFG_KEY_W4:    key_r[4]  <= cfg_wdata;
          smbsv_pkg::CFG_SEQ_START: cnt_r     <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CRND && rnd_r == 6'd63 |=> state_r == S_CADD)
    else $error("compression did not end after the last round");

  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_KEY || state_r == S_BYTE || state_r == S_PAD))
    else $error("block write outside an absorb step");

  a_key_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KEY |-> kidx_r < kl_r)
    else $error("key index ran past key length");

  a_fin_res: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> state_r == S_RES)
    else $error("digest not handed to result stage");

endmodule
